@@ rtl/swf_pkg.sv @@
// Shared types, register map and a helper function of the straight wire field kernel.
package swf_pkg;

    localparam int NUM_REGS = 8;
    localparam int ADDR_W   = 5;

    // Root unit: radicand width (the root has half as many bits).
    localparam int SQ_W   = 64;
    // Divide unit: numerator magnitude, divisor and quotient magnitude widths.
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 32;
    localparam int DIV_QW = 33;

    typedef enum logic [2:0] {
        REG_START_X,
        REG_START_Y,
        REG_START_Z,
        REG_END_X,
        REG_END_Y,
        REG_END_Z,
        REG_CUR_RE,
        REG_CUR_IM
    } t_reg_idx;

    localparam logic [31:0] CFG_RESET [NUM_REGS] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0001_0000, 32'h0000_0000
    };

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] bre_x;
        logic signed [31:0] bre_y;
        logic signed [31:0] bre_z;
        logic signed [31:0] bim_x;
        logic signed [31:0] bim_y;
        logic signed [31:0] bim_z;
        logic               degenerate;
    } t_out_item;

    // Geometry handed from the front end to the length and divide section.
    typedef struct packed {
        logic        [2:0][31:0] cn;
        logic        [2:0][31:0] s;
        logic        [2:0][31:0] d1;
        logic        [2:0][31:0] d2;
        logic signed [7:0]       rsh;
        logic                    degen;
    } t_front;

    // Position of the highest set bit plus one; zero for a zero word.
    function automatic logic [6:0] bitlen64(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/straight_wire_field_kernel.sv @@
// Top level of the straight wire field kernel: register port, pipeline and valid tracking.
//
// Flux density of a finite straight current segment at one field point per
// item, in Q16.16 with B in units of 100 nT. The block accepts one item in
// every cycle while the output does not stall; the pipeline depth comes from
// the 33-stage square root unit and the two 34-stage divide units in series,
// one result bit per stage, plus seven front-end stages, a few sum and
// multiply stages and five output stages. A stall at the output holds the
// whole pipeline, so nothing is lost or repeated. Segment end points and the
// complex current sit in eight 32-bit registers at byte addresses 4*i and
// must only be written while no item is in flight. A point on the wire line
// gives zero flux and sets the degenerate flag.
module straight_wire_field_kernel import swf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LF    = 7;
    localparam int LS    = SQ_W / 2 + 1;
    localparam int LD    = DIV_QW + 1;
    localparam int LO    = 5;
    localparam int D_CN  = 2 + LS + LD + 1;
    localparam int D_RSH = D_CN + LD;
    localparam int LAT   = LF + D_RSH + LO;

    logic [31:0]             r_cfg [NUM_REGS];
    logic [LAT-1:0]          r_vld;
    logic                    w_en;
    t_front                  w_front;
    logic [63:0]             r_sqc [3];
    logic [63:0]             r_sq1 [3];
    logic [63:0]             r_sq2 [3];
    logic signed [63:0]      r_pd1 [3];
    logic signed [63:0]      r_pd2 [3];
    logic [63:0]             r_ncn_sq, r_len1_sq, r_len2_sq;
    logic signed [63:0]      r_dot1, r_dot2;
    logic [SQ_W/2-1:0]       w_ncn, w_len1, w_len2;
    logic [127:0]            w_dot_d;
    logic signed [63:0]      w_dot1, w_dot2;
    logic signed [DIV_QW:0]  w_t1, w_t2;
    logic signed [DIV_QW+1:0] r_g;
    logic [DIV_QW+1:0]       w_gm;
    logic [SQ_W/2-1:0]       w_ncn_d;
    logic [2:0][31:0]        w_cn_d;
    logic signed [DIV_QW:0]  w_h;
    logic signed [DIV_QW:0]  w_u [3];
    logic signed [7:0]       w_rsh_d;
    logic                    w_degen_d;
    logic signed [31:0]      w_b [6];

    // Register port: writes on the access phase, reads straight from the file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (psel && penable && pwrite) begin
            r_cfg[paddr[ADDR_W-1:2]] <= pwdata;
        end
    end

    assign prdata = r_cfg[paddr[ADDR_W-1:2]];
    assign pready = 1'b1;

    // The pipeline moves unless a finished item waits at the output.
    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    swf_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_start ({r_cfg[REG_START_Z], r_cfg[REG_START_Y], r_cfg[REG_START_X]}),
        .i_end   ({r_cfg[REG_END_Z], r_cfg[REG_END_Y], r_cfg[REG_END_X]}),
        .i_point ({i_in_data.point_z, i_in_data.point_y, i_in_data.point_x}),
        .o_front (w_front)
    );

    // Squares and dot product terms.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sqc[i] <= 64'($signed(w_front.cn[i]) * $signed(w_front.cn[i]));
                r_sq1[i] <= 64'($signed(w_front.d1[i]) * $signed(w_front.d1[i]));
                r_sq2[i] <= 64'($signed(w_front.d2[i]) * $signed(w_front.d2[i]));
                r_pd1[i] <= $signed(w_front.s[i]) * $signed(w_front.d1[i]);
                r_pd2[i] <= $signed(w_front.s[i]) * $signed(w_front.d2[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ncn_sq  <= r_sqc[0] + r_sqc[1] + r_sqc[2];
            r_len1_sq <= r_sq1[0] + r_sq1[1] + r_sq1[2];
            r_len2_sq <= r_sq2[0] + r_sq2[1] + r_sq2[2];
            r_dot1    <= r_pd1[0] + r_pd1[1] + r_pd1[2];
            r_dot2    <= r_pd2[0] + r_pd2[1] + r_pd2[2];
        end
    end

    // Lengths of the cross product and of both point offsets.
    swf_sqrt #(.W(SQ_W)) u_sqrt_ncn (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_ncn_sq), .o_root(w_ncn)
    );
    swf_sqrt #(.W(SQ_W)) u_sqrt_len1 (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_len1_sq), .o_root(w_len1)
    );
    swf_sqrt #(.W(SQ_W)) u_sqrt_len2 (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_len2_sq), .o_root(w_len2)
    );

    swf_delay #(.W(128), .D(LS)) u_dly_dot (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_dot2, r_dot1}), .o_q(w_dot_d)
    );
    assign w_dot1 = $signed(w_dot_d[63:0]);
    assign w_dot2 = $signed(w_dot_d[127:64]);

    // End-angle terms: dot product over offset length.
    swf_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_t1 (
        .i_clk (i_clk), .i_en(w_en), .i_neg(w_dot1[63]),
        .i_num (w_dot1[63] ? DIV_NW'(-w_dot1) : DIV_NW'(w_dot1)),
        .i_den (DIV_DW'(w_len1)), .o_quot(w_t1)
    );
    swf_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_t2 (
        .i_clk (i_clk), .i_en(w_en), .i_neg(w_dot2[63]),
        .i_num (w_dot2[63] ? DIV_NW'(-w_dot2) : DIV_NW'(w_dot2)),
        .i_den (DIV_DW'(w_len2)), .o_quot(w_t2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g <= (DIV_QW+2)'(w_t1) - (DIV_QW+2)'(w_t2);
        end
    end

    assign w_gm = r_g[DIV_QW+1] ? (DIV_QW+2)'(-r_g) : (DIV_QW+2)'(r_g);

    swf_delay #(.W(SQ_W/2), .D(LD + 1)) u_dly_ncn (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_ncn), .o_q(w_ncn_d)
    );
    swf_delay #(.W(96), .D(D_CN)) u_dly_cn (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_front.cn), .o_q(w_cn_d)
    );
    swf_delay #(.W(8), .D(D_RSH)) u_dly_rsh (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_front.rsh), .o_q(w_rsh_d)
    );
    swf_delay #(.W(1), .D(D_RSH + LO)) u_dly_degen (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_front.degen), .o_q(w_degen_d)
    );

    // Magnitude over distance, and the unit direction.
    swf_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_h (
        .i_clk (i_clk), .i_en(w_en), .i_neg(r_g[DIV_QW+1]),
        .i_num (DIV_NW'({w_gm, 28'b0})),
        .i_den (DIV_DW'(w_ncn_d)), .o_quot(w_h)
    );

    for (genvar g = 0; g < 3; g++) begin : g_dir
        logic [31:0] cm;
        assign cm = w_cn_d[g][31] ? 32'(-$signed(w_cn_d[g])) : w_cn_d[g];
        swf_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_u (
            .i_clk (i_clk), .i_en(w_en), .i_neg(w_cn_d[g][31]),
            .i_num (DIV_NW'({cm, 30'b0})),
            .i_den (DIV_DW'(w_ncn_d)), .o_quot(w_u[g])
        );
    end

    // Six output components: real then imaginary, x, y, z.
    for (genvar g = 0; g < 6; g++) begin : g_out
        swf_outc u_outc (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_cur ((g < 3) ? $signed(r_cfg[REG_CUR_RE]) : $signed(r_cfg[REG_CUR_IM])),
            .i_u   (w_u[g % 3]),
            .i_h   (w_h),
            .i_rsh (w_rsh_d),
            .o_b   (w_b[g])
        );
    end

    // A point on the wire line reports zero flux.
    assign o_out_data.bre_x      = w_degen_d ? '0 : w_b[0];
    assign o_out_data.bre_y      = w_degen_d ? '0 : w_b[1];
    assign o_out_data.bre_z      = w_degen_d ? '0 : w_b[2];
    assign o_out_data.bim_x      = w_degen_d ? '0 : w_b[3];
    assign o_out_data.bim_y      = w_degen_d ? '0 : w_b[4];
    assign o_out_data.bim_z      = w_degen_d ? '0 : w_b[5];
    assign o_out_data.degenerate = w_degen_d;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An item one stage from the end reaches the output when the pipeline moves.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_vld[LAT-2] |=> o_out_valid)
        else $error("item lost in the last stage");

    // A degenerate result carries no flux; checked on bre_x, bim_x and bre_z.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.bre_x == 0 && o_out_data.bim_x == 0 && o_out_data.bre_z == 0)
        else $error("degenerate item with nonzero flux");

endmodule

@@ rtl/swf_delay.sv @@
// Enabled shift line that delays a word by a fixed number of stages.
module swf_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [D];

    // Shift one place whenever the pipeline moves.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_q = r_line[D-1];

endmodule

@@ rtl/swf_sqrt.sv @@
// Pipelined floor integer square root, one result bit per stage.
module swf_sqrt import swf_pkg::*; #(
    parameter int W = SQ_W
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_x,
    output logic [W/2-1:0] o_root
);

    localparam int N = W / 2;

    logic [W-1:0] r_x [N];
    logic [W-1:0] r_r [N+1];

    // Capture the radicand.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_x;
            r_r[0] <= '0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * g);
        logic [W:0] trial;
        logic       take;
        assign trial = {1'b0, r_r[g]} + {1'b0, BIT};
        assign take  = {1'b0, r_x[g]} >= trial;

        // One digit of the root: subtract the trial value when it fits.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[g+1] <= take ? (r_r[g] >> 1) + BIT : r_r[g] >> 1;
            end
        end

        if (g < N - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g+1] <= take ? r_x[g] - trial[W-1:0] : r_x[g];
                end
            end
        end
    end

    assign o_root = r_r[N][N-1:0];

endmodule

@@ rtl/swf_div.sv @@
// Pipelined signed divide by a positive divisor, truncating toward zero.
module swf_div import swf_pkg::*; #(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW,
    parameter int QW = DIV_QW
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_neg,
    input  logic [NW-1:0]       i_num,
    input  logic [DW-1:0]       i_den,
    output logic signed [QW:0]  o_quot
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_q    [QW+1];
    logic          r_neg  [QW+1];
    logic          r_zero [QW+1];

    // The quotient is known to fit in QW bits, so the top numerator bits
    // seed the remainder directly.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DW'(i_num >> QW);
            r_low[0]  <= i_num[QW-1:0];
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_neg[0]  <= i_neg;
            r_zero[0] <= (i_den == '0);
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [DW:0] trial;
        logic        take;
        assign trial = {r_rem[g], r_low[g][QW-1-g]};
        assign take  = trial >= {1'b0, r_den[g]};

        // One quotient bit per stage.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g+1]    <= {r_q[g][QW-2:0], take};
                r_neg[g+1]  <= r_neg[g];
                r_zero[g+1] <= r_zero[g];
            end
        end

        if (g < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g+1] <= take ? DW'(trial - {1'b0, r_den[g]}) : DW'(trial);
                    r_low[g+1] <= r_low[g];
                    r_den[g+1] <= r_den[g];
                end
            end
        end
    end

    // Apply the sign; a zero divisor gives zero.
    always_comb begin
        if (r_zero[QW]) begin
            o_quot = '0;
        end else if (r_neg[QW]) begin
            o_quot = -$signed({1'b0, r_q[QW]});
        end else begin
            o_quot = $signed({1'b0, r_q[QW]});
        end
    end

endmodule

@@ rtl/swf_front.sv @@
// Front end: differences, block scaling, cross product and its normalization.
module swf_front import swf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [2:0][31:0] i_start,
    input  logic [2:0][31:0] i_end,
    input  logic [2:0][31:0] i_point,
    output t_front           o_front
);

    typedef struct packed {
        logic [2:0][31:0] s;
        logic [2:0][31:0] d1;
        logic [2:0][31:0] d2;
    } t_geo;

    // Scale by 2^(30 - bl); right shifts truncate the magnitude.
    function automatic logic signed [31:0] scale(input logic signed [63:0] v,
                                                 input logic [6:0] bl);
        logic [63:0] m;
        logic [63:0] q;
        m = v[63] ? 64'(-v) : 64'(v);
        if (bl <= 7'd30) begin
            q = m << (7'd30 - bl);
        end else begin
            q = m >> (bl - 7'd30);
        end
        return v[63] ? -$signed(q[31:0]) : $signed(q[31:0]);
    endfunction

    logic signed [32:0] r1_s [3];
    logic signed [32:0] r1_d [3];
    logic signed [32:0] r2_s [3];
    logic signed [32:0] r2_d [3];
    logic [6:0]         r2_bl;
    t_geo               r3_geo, r4_geo, r5_geo, r6_geo, r7_geo;
    logic [6:0]         r3_bl, r4_bl, r5_bl, r6_bl;
    logic signed [63:0] r4_p [6];
    logic signed [63:0] r5_c [3];
    logic signed [63:0] r6_c [3];
    logic [6:0]         r6_blc;
    logic [2:0][31:0]   r7_cn;
    logic signed [7:0]  r7_rsh;
    logic               r7_degen;

    logic [32:0] n_or_m;
    logic [63:0] n_or_c;

    // Wire vector and point offset, exact in 33 bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_s[i] <= $signed({i_end[i][31], i_end[i]})
                         - $signed({i_start[i][31], i_start[i]});
                r1_d[i] <= $signed({i_point[i][31], i_point[i]})
                         - $signed({i_start[i][31], i_start[i]});
            end
        end
    end

    // Common exponent of the six components.
    always_comb begin
        n_or_m = '0;
        for (int i = 0; i < 3; i++) begin
            n_or_m = n_or_m | (r1_s[i][32] ? 33'(-r1_s[i]) : 33'(r1_s[i]))
                            | (r1_d[i][32] ? 33'(-r1_d[i]) : 33'(r1_d[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_s  <= r1_s;
            r2_d  <= r1_d;
            r2_bl <= bitlen64({31'b0, n_or_m});
        end
    end

    // Scale to 30 significant bits and form the offset from the wire end.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_geo.s[i]  <= scale(64'(r2_s[i]), r2_bl);
                r3_geo.d1[i] <= scale(64'(r2_d[i]), r2_bl);
                r3_geo.d2[i] <= scale(64'(r2_d[i]), r2_bl) - scale(64'(r2_s[i]), r2_bl);
            end
            r3_bl <= r2_bl;
        end
    end

    // Cross product partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_p[0] <= $signed(r3_geo.s[1]) * $signed(r3_geo.d1[2]);
            r4_p[1] <= $signed(r3_geo.s[2]) * $signed(r3_geo.d1[1]);
            r4_p[2] <= $signed(r3_geo.s[2]) * $signed(r3_geo.d1[0]);
            r4_p[3] <= $signed(r3_geo.s[0]) * $signed(r3_geo.d1[2]);
            r4_p[4] <= $signed(r3_geo.s[0]) * $signed(r3_geo.d1[1]);
            r4_p[5] <= $signed(r3_geo.s[1]) * $signed(r3_geo.d1[0]);
            r4_geo  <= r3_geo;
            r4_bl   <= r3_bl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_c[0] <= r4_p[0] - r4_p[1];
            r5_c[1] <= r4_p[2] - r4_p[3];
            r5_c[2] <= r4_p[4] - r4_p[5];
            r5_geo  <= r4_geo;
            r5_bl   <= r4_bl;
        end
    end

    // Exponent of the cross product.
    always_comb begin
        n_or_c = '0;
        for (int i = 0; i < 3; i++) begin
            n_or_c = n_or_c | (r5_c[i][63] ? 64'(-r5_c[i]) : 64'(r5_c[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_c   <= r5_c;
            r6_blc <= bitlen64(n_or_c);
            r6_geo <= r5_geo;
            r6_bl  <= r5_bl;
        end
    end

    // Normalized cross product; a zero cross product marks the wire line.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r7_cn[i] <= scale(r6_c[i], r6_blc);
            end
            r7_geo   <= r6_geo;
            r7_rsh   <= $signed({1'b0, r6_bl}) + $signed({1'b0, r6_blc}) - 8'sd18;
            r7_degen <= (r6_blc == 7'd0);
        end
    end

    assign o_front.cn    = r7_cn;
    assign o_front.s     = r7_geo.s;
    assign o_front.d1    = r7_geo.d1;
    assign o_front.d2    = r7_geo.d2;
    assign o_front.rsh   = r7_rsh;
    assign o_front.degen = r7_degen;

endmodule

@@ rtl/swf_outc.sv @@
// One flux component: current times direction times magnitude, rounded and saturated.
module swf_outc (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_cur,
    input  logic signed [33:0] i_u,
    input  logic signed [33:0] i_h,
    input  logic signed [7:0]  i_rsh,
    output logic signed [31:0] o_b
);

    logic [31:0]        n_cm;
    logic [33:0]        n_um;
    logic [33:0]        n_hm;
    logic [63:0]        r1_a;
    logic [32:0]        r1_hm;
    logic               r1_neg, r2_neg, r3_neg, r4_neg;
    logic signed [7:0]  r1_rsh, r2_rsh, r3_rsh, r4_rsh;
    logic [64:0]        r2_p0, r2_p1;
    logic [96:0]        r3_full;
    logic [96:0]        r4_rnd;
    logic [112:0]       n_v;
    logic [31:0]        n_limit;
    logic [31:0]        n_lo;
    logic signed [31:0] r5_b;

    assign n_cm = i_cur[31] ? 32'(-i_cur) : 32'(i_cur);
    assign n_um = i_u[33] ? 34'(-i_u) : 34'(i_u);
    assign n_hm = i_h[33] ? 34'(-i_h) : 34'(i_h);

    // Current times the unit direction component, on magnitudes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a   <= n_cm * n_um[31:0];
            r1_hm  <= n_hm[32:0];
            r1_neg <= i_cur[31] ^ i_u[33] ^ i_h[33];
            r1_rsh <= i_rsh;
        end
    end

    // Multiply by the magnitude term in two halves.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p0  <= r1_a[31:0] * r1_hm;
            r2_p1  <= r1_a[63:32] * r1_hm;
            r2_neg <= r1_neg;
            r2_rsh <= r1_rsh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_full <= 97'(r2_p0) + {r2_p1, 32'b0};
            r3_neg  <= r2_neg;
            r3_rsh  <= r2_rsh;
        end
    end

    // Round half away from zero ahead of a right shift.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r3_rsh > 8'sd0) begin
                r4_rnd <= r3_full + (97'(1) << 7'(r3_rsh - 8'sd1));
            end else begin
                r4_rnd <= r3_full;
            end
            r4_neg <= r3_neg;
            r4_rsh <= r3_rsh;
        end
    end

    // Final shift, saturation to the signed range and sign.
    always_comb begin
        if (r4_rsh > 8'sd0) begin
            n_v = 113'(r4_rnd >> 7'(r4_rsh));
        end else begin
            n_v = 113'(r4_rnd) << 5'(-r4_rsh);
        end
        n_limit = r4_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        n_lo    = (n_v > {81'b0, n_limit}) ? n_limit : n_v[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_b <= r4_neg ? -$signed(n_lo) : $signed(n_lo);
        end
    end

    assign o_b = r5_b;

endmodule

@@ test/swf_field_checker.sv @@
// Checker for the straight wire field kernel: mirrors registers, predicts flux and compares.
`timescale 1ns / 100ps

module swf_field_checker import swf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                o_pending,
    output int                o_fail_count
);

    logic signed [31:0] wire_regs [NUM_REGS];
    t_out_item          flux_expected [$];
    int                 fail_count;

    assign o_pending    = flux_expected.size();
    assign o_fail_count = fail_count;

    function automatic longint unsigned abs64(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic int bit_length(input longint unsigned v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    // Multiply by 2^n; a negative n truncates the magnitude toward zero.
    function automatic longint shift_pow2(input longint v, input int n);
        longint unsigned mg;
        if (n >= 0) begin
            return v <<< n;
        end
        mg = abs64(v) >> (-n);
        return v < 0 ? -longint'(mg) : longint'(mg);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Exact triple product, rounded half away from zero and saturated.
    function automatic logic [31:0] flux_component(input longint cur, input longint u,
                                                   input longint h, input int rsh);
        logic [127:0] prod, lim;
        logic [31:0]  res;
        logic         neg;
        neg  = (cur < 0) ^ (u < 0) ^ (h < 0);
        prod = 128'(abs64(cur)) * 128'(abs64(u)) * 128'(abs64(h));
        lim  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (rsh > 0) begin
            prod = (prod + (128'd1 << (rsh - 1))) >> rsh;
            if (prod > lim) prod = lim;
        end else if (rsh < 0) begin
            if (prod > (lim >> (-rsh))) prod = lim;
            else prod = prod << (-rsh);
        end else if (prod > lim) begin
            prod = lim;
        end
        res = prod[31:0];
        return neg ? -res : res;
    endfunction

    function automatic t_out_item predict_flux(input t_in_item pt);
        t_out_item       r;
        longint          s [3], d1 [3], d2 [3], c [3], cn [3], u [3], p [3];
        longint          dot1, dot2, g, h, t1, t2;
        longint unsigned m, mc, len1, len2, ncn;
        int              k, j;
        r = '0;
        p[0] = pt.point_x;
        p[1] = pt.point_y;
        p[2] = pt.point_z;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            s[i]  = longint'(wire_regs[REG_END_X + i]) - longint'(wire_regs[REG_START_X + i]);
            d1[i] = p[i] - longint'(wire_regs[REG_START_X + i]);
            if (abs64(s[i]) > m) m = abs64(s[i]);
            if (abs64(d1[i]) > m) m = abs64(d1[i]);
        end
        // Point coincides with both ends, so nothing to scale.
        if (m == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        k = bit_length(m) - 30;
        for (int i = 0; i < 3; i++) begin
            s[i]  = shift_pow2(s[i], -k);
            d1[i] = shift_pow2(d1[i], -k);
            d2[i] = d1[i] - s[i];
        end
        c[0] = s[1] * d1[2] - s[2] * d1[1];
        c[1] = s[2] * d1[0] - s[0] * d1[2];
        c[2] = s[0] * d1[1] - s[1] * d1[0];
        mc = 0;
        for (int i = 0; i < 3; i++) begin
            if (abs64(c[i]) > mc) mc = abs64(c[i]);
        end
        // Point on the wire line.
        if (mc == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        j = bit_length(mc) - 30;
        for (int i = 0; i < 3; i++) cn[i] = shift_pow2(c[i], -j);
        ncn = floor_sqrt(64'(cn[0] * cn[0]) + 64'(cn[1] * cn[1]) + 64'(cn[2] * cn[2]));

        // End-angle terms and the unit direction.
        dot1 = s[0] * d1[0] + s[1] * d1[1] + s[2] * d1[2];
        dot2 = s[0] * d2[0] + s[1] * d2[1] + s[2] * d2[2];
        len1 = floor_sqrt(64'(d1[0] * d1[0]) + 64'(d1[1] * d1[1]) + 64'(d1[2] * d1[2]));
        len2 = floor_sqrt(64'(d2[0] * d2[0]) + 64'(d2[1] * d2[1]) + 64'(d2[2] * d2[2]));
        t1 = (len1 == 0) ? 0 : dot1 / longint'(len1);
        t2 = (len2 == 0) ? 0 : dot2 / longint'(len2);
        g  = t1 - t2;
        h  = (g <<< 28) / longint'(ncn);
        for (int i = 0; i < 3; i++) u[i] = (cn[i] <<< 30) / longint'(ncn);

        r.bre_x = flux_component(wire_regs[REG_CUR_RE], u[0], h, 42 + k + j);
        r.bre_y = flux_component(wire_regs[REG_CUR_RE], u[1], h, 42 + k + j);
        r.bre_z = flux_component(wire_regs[REG_CUR_RE], u[2], h, 42 + k + j);
        r.bim_x = flux_component(wire_regs[REG_CUR_IM], u[0], h, 42 + k + j);
        r.bim_y = flux_component(wire_regs[REG_CUR_IM], u[1], h, 42 + k + j);
        r.bim_z = flux_component(wire_regs[REG_CUR_IM], u[2], h, 42 + k + j);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Register mirror, prediction on each accepted item, comparison on each result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) wire_regs[i] = CFG_RESET[i];
        end else begin
            if (psel && penable && pwrite && pready) begin
                wire_regs[paddr[ADDR_W-1:2]] = pwdata;
            end
            if (i_in_valid && i_in_ready) begin
                flux_expected.push_back(predict_flux(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (flux_expected.size() == 0) begin
                    report_mismatch("unexpected item", 32'(i_out_data.degenerate), 32'd0);
                end else begin
                    want = flux_expected.pop_front();
                    if (i_out_data.bre_x !== want.bre_x)
                        report_mismatch("bre_x", i_out_data.bre_x, want.bre_x);
                    if (i_out_data.bre_y !== want.bre_y)
                        report_mismatch("bre_y", i_out_data.bre_y, want.bre_y);
                    if (i_out_data.bre_z !== want.bre_z)
                        report_mismatch("bre_z", i_out_data.bre_z, want.bre_z);
                    if (i_out_data.bim_x !== want.bim_x)
                        report_mismatch("bim_x", i_out_data.bim_x, want.bim_x);
                    if (i_out_data.bim_y !== want.bim_y)
                        report_mismatch("bim_y", i_out_data.bim_y, want.bim_y);
                    if (i_out_data.bim_z !== want.bim_z)
                        report_mismatch("bim_z", i_out_data.bim_z, want.bim_z);
                    if (i_out_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", 32'(i_out_data.degenerate),
                                        32'(want.degenerate));
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

@@ test/tb_straight_wire_field_kernel.sv @@
// Testbench top for the straight wire field kernel: stimulus, register writes and verdict.
`timescale 1ns / 100ps

module tb_straight_wire_field_kernel;
    import swf_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int pending, fail_count;
    int idle_mode = 0;
    int points_sent = 0;
    int results_seen = 0;
    logic signed [31:0] wire_cfg [NUM_REGS];

    always #2 i_clk = ~i_clk;

    straight_wire_field_kernel u_top (.*);

    swf_field_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_data(o_out_data),
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) results_seen++;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        wire_cfg[idx] = val;
    endtask

    task automatic set_wire(input logic [31:0] sx, sy, sz, ex, ey, ez, cre, cim);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_START_Z, sz);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        write_reg(REG_END_Z, ez);
        write_reg(REG_CUR_RE, cre);
        write_reg(REG_CUR_IM, cim);
    endtask

    // Offer one item, with random gaps before it, and hold it until accepted.
    task automatic send_point(input logic [31:0] px, py, pz);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 35 : (idle_mode == 1) ? 75 : 0;
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= '{point_x: px, point_y: py, point_z: pz};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        points_sent++;
        idle_mode = (points_sent < 400) ? 0 : (points_sent < 800) ? 1 : 2;
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    // Points mostly near the segment, some on its line, some anywhere.
    task automatic send_random_points(input int count);
        longint st, sp, off;
        logic [31:0] pt [3];
        int sel, tnum;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(9);
            tnum = $urandom_range(256);
            for (int i = 0; i < 3; i++) begin
                st = wire_cfg[REG_START_X + i];
                sp = longint'(wire_cfg[REG_END_X + i]) - st;
                if (sel < 2) begin
                    pt[i] = $urandom;
                end else if (sel == 2) begin
                    pt[i] = 32'(st + sp * (tnum - 64) / 64);
                end else begin
                    off = longint'($urandom_range((1 << $urandom_range(20)) * 2))
                          - (1 << $urandom_range(20));
                    pt[i] = 32'(st + sp * (tnum - 64) / 128 + off);
                end
            end
            send_point(pt[0], pt[1], pt[2]);
        end
    endtask

    // Receiver: random stalls per phase, plus one long hold-off to fill the pipeline.
    initial begin
        bit held;
        int stall_pct;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 200) begin
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                held = 1;
            end else begin
                stall_pct = (idle_mode == 0) ? 75 : (idle_mode == 1) ? 35 : 0;
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_REGS; i++) wire_cfg[i] = CFG_RESET[i];
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset wire along x from 0 to 1: ends, line, near line, field extremes.
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0001_0000, 32'h0, 32'h0);
        send_point(32'h0000_8000, 32'h0, 32'h0);
        send_point(32'h0002_0000, 32'h0, 32'h0);
        send_point(32'hFFFF_0000, 32'h0, 32'h0);
        send_point(32'h0000_8000, 32'h0001_0000, 32'h0);
        send_point(32'h0000_8000, 32'h0, 32'h0001_0000);
        send_point(32'h0000_8000, 32'h1, 32'h0);
        send_point(32'h0000_8000, 32'h0, 32'hFFFF_FFFF);
        send_point(32'h0, 32'h0001_0000, 32'h0);
        send_point(32'h0001_0000, 32'h0, 32'h0001_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_point(32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        send_point(32'h0000_8000, 32'h7FFF_FFFF, 32'h0);
        send_point(32'h0000_8000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Widest wire and extreme currents.
        set_wire(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_random_points(60);
        drain();

        // Zero-length wire: every point is degenerate.
        set_wire(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, $urandom, $urandom);
        send_random_points(20);
        drain();

        // Random short wires with random currents, extreme ones in the last phase.
        for (int ph = 0; ph < 6; ph++) begin
            logic [31:0] sx, sy, sz;
            sx = 32'($signed($urandom_range(1 << 21)) - (1 << 20));
            sy = 32'($signed($urandom_range(1 << 21)) - (1 << 20));
            sz = 32'($signed($urandom_range(1 << 21)) - (1 << 20));
            set_wire(sx, sy, sz,
                     sx + $urandom_range(1 << 19) - (1 << 18),
                     sy + $urandom_range(1 << 19) - (1 << 18),
                     sz + $urandom_range(1 << 19) - (1 << 18),
                     (ph == 5) ? 32'h8000_0000 : $urandom,
                     (ph == 5) ? 32'h7FFF_FFFF : $urandom);
            send_random_points(185);
            drain();
        end

        repeat (130) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/swf_pkg.sv
rtl/swf_delay.sv
rtl/swf_sqrt.sv
rtl/swf_div.sv
rtl/swf_front.sv
rtl/swf_outc.sv
rtl/straight_wire_field_kernel.sv
test/swf_field_checker.sv
test/tb_straight_wire_field_kernel.sv
